// ===== src/quaternion_nlerp_macros.svh =====
// ----------------------------------------------------------------------------
// Quaternion NLERP assertion macros
// Shared concurrent assertion forms, clocked on i_clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_NLERP_MACROS_SVH
`define QUATERNION_NLERP_MACROS_SVH

// Same-cycle implication.
`define QN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qn_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion NLERP package
// Fixed-point widths and the stage records passed along the cell chains.
// ----------------------------------------------------------------------------
`default_nettype none

package qn_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int W_IN      = 16;
    localparam int W_BLEND   = 15;
    localparam int W_MAG     = 16;
    localparam int W_SUM     = 33;
    localparam int SQ_EXT    = 20;
    localparam int W_RAD     = 54;
    localparam int SQ_CELLS  = W_RAD / 2;
    localparam int W_ROOT    = SQ_CELLS;
    localparam int W_REM     = W_ROOT + 1;
    localparam int NUM_SHIFT = FRAC_BITS + SQ_EXT / 2;
    localparam int W_DIV     = W_ROOT + FRAC_BITS;
    localparam int DIV_CELLS = FRAC_BITS + 1;
    localparam int W_QUO     = DIV_CELLS;

    typedef struct packed {
        logic                       vld;
        logic [3:0]                 neg;
        logic [3:0][W_MAG-1:0]      mag;
        logic [W_SUM-1:0]           sum;
    } t_front;

    typedef struct packed {
        logic                       vld;
        logic [3:0]                 neg;
        logic [3:0][W_MAG-1:0]      mag;
        logic [W_RAD-1:0]           rad;
        logic [W_REM-1:0]           rem;
        logic [W_ROOT-1:0]          root;
    } t_sq;

    typedef struct packed {
        logic                       vld;
        logic                       degen;
        logic [3:0]                 neg;
        logic [W_DIV-1:0]           dsor;
        logic [3:0][W_DIV-1:0]      part;
        logic [3:0][W_QUO-1:0]      quo;
    } t_div;

endpackage

`default_nettype wire

// ===== src/quaternion_nlerp.sv =====
// ----------------------------------------------------------------------------
// Quaternion NLERP top level
// Shortest-path normalised blend of two unit quaternions, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (i_valid / o_ready) carries both quaternions
// and the blend factor. The result leaves on the output channel
// (o_valid / i_ready) with the normalised quaternion and a degenerate flag,
// set when the blend has zero length and the identity is returned.
// From acceptance to o_valid a request passes six front-end stages, 27
// square root cells (one root bit each), one set-up stage, 15 divider cells
// (one quotient bit each) and the output register. Throughput is one request
// per cycle while o_ready is high; every stage holds its own request.
// When the receiver stalls, a skid register catches the request leaving the
// last cell; while it is full the whole chain holds and o_ready is low.
// Reset clears all valid bits; the first request may be sent directly after.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_nlerp_macros.svh"

module quaternion_nlerp import qn_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [W_IN-1:0]      i_a_w,
    input  logic signed [W_IN-1:0]      i_a_x,
    input  logic signed [W_IN-1:0]      i_a_y,
    input  logic signed [W_IN-1:0]      i_a_z,
    input  logic signed [W_IN-1:0]      i_b_w,
    input  logic signed [W_IN-1:0]      i_b_x,
    input  logic signed [W_IN-1:0]      i_b_y,
    input  logic signed [W_IN-1:0]      i_b_z,
    input  logic [W_BLEND-1:0]          i_blend,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [W_IN-1:0]      o_out_w,
    output logic signed [W_IN-1:0]      o_out_x,
    output logic signed [W_IN-1:0]      o_out_y,
    output logic signed [W_IN-1:0]      o_out_z,
    output logic                        o_degenerate
);

    typedef struct packed {
        logic [3:0][W_IN-1:0]  val;
        logic                  degen;
    } t_res;

    logic                  en;
    logic                  take;
    t_front                front;
    t_sq                   sq_ch [SQ_CELLS+1];
    t_div                  dv_ch [DIV_CELLS+1];
    t_div                  n_prep;
    t_div                  r_prep;
    t_res                  res;
    t_res                  r_out;
    t_res                  r_skid;
    logic                  r_out_vld;
    logic                  r_skid_vld;
    logic [W_IN-1:0]       q_ext [4];
    t_div                  last;

    assign en      = !r_skid_vld;
    assign o_ready = en;
    assign take    = !r_out_vld || i_ready;

    qn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_a     ({i_a_z, i_a_y, i_a_x, i_a_w}),
        .i_b     ({i_b_z, i_b_y, i_b_x, i_b_w}),
        .i_blend (i_blend),
        .o_front (front)
    );

    always_comb begin
        sq_ch[0].vld  = front.vld;
        sq_ch[0].neg  = front.neg;
        sq_ch[0].mag  = front.mag;
        sq_ch[0].rad  = W_RAD'({front.sum, {SQ_EXT{1'b0}}});
        sq_ch[0].rem  = '0;
        sq_ch[0].root = '0;
    end

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
        qn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_sq    (sq_ch[k]),
            .o_sq    (sq_ch[k+1])
        );
    end

    // Rounded division: the half divisor is added to the dividend up front.
    always_comb begin
        n_prep.vld   = sq_ch[SQ_CELLS].vld;
        n_prep.neg   = sq_ch[SQ_CELLS].neg;
        n_prep.degen = (sq_ch[SQ_CELLS].root == '0);
        n_prep.dsor  = W_DIV'({sq_ch[SQ_CELLS].root, {FRAC_BITS{1'b0}}});
        n_prep.quo   = '0;
        for (int i = 0; i < 4; i++) begin
            n_prep.part[i] = W_DIV'({sq_ch[SQ_CELLS].mag[i], {NUM_SHIFT{1'b0}}})
                           + W_DIV'(sq_ch[SQ_CELLS].root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.vld <= 1'b0;
        end else if (en) begin
            r_prep <= n_prep;
        end
    end

    assign dv_ch[0] = r_prep;

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        qn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_dv    (dv_ch[k]),
            .o_dv    (dv_ch[k+1])
        );
    end

    assign last = dv_ch[DIV_CELLS];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q_ext[i]   = W_IN'(last.quo[i]);
            res.val[i] = last.neg[i] ? W_IN'(-q_ext[i]) : q_ext[i];
        end
        res.degen = last.degen;
        if (last.degen) begin
            res.val    = '0;
            res.val[0] = W_IN'(ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (take) begin
                r_out_vld <= r_skid_vld || (en && last.vld);
            end
            if (r_skid_vld && take) begin
                r_skid_vld <= 1'b0;
            end else if (en && last.vld && !take) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_vld ? r_skid : res;
        end
        if (en && last.vld && !take) begin
            r_skid <= res;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_out_w      = r_out.val[0];
    assign o_out_x      = r_out.val[1];
    assign o_out_y      = r_out.val[2];
    assign o_out_z      = r_out.val[3];
    assign o_degenerate = r_out.degen;

    `QN_ASSERT_IMP(a_skid_behind_out, r_skid_vld, r_out_vld,
        "skid register holds a request while the output register is empty")
    `QN_ASSERT_NXT(a_skid_holds, r_skid_vld && !i_ready, r_skid_vld,
        "skid register dropped a request while the receiver stalled")
    `QN_ASSERT_IMP(a_identity, o_valid && o_degenerate,
        (o_out_x == '0) && (o_out_y == '0) && (o_out_z == '0) && (o_out_w == W_IN'(ONE)),
        "degenerate result is not the identity")
    `QN_ASSERT_IMP(a_unit_range, o_valid && !o_degenerate,
        ($signed(o_out_w) <= ONE) && ($signed(o_out_w) >= -ONE) &&
        ($signed(o_out_x) <= ONE) && ($signed(o_out_x) >= -ONE) &&
        ($signed(o_out_y) <= ONE) && ($signed(o_out_y) >= -ONE) &&
        ($signed(o_out_z) <= ONE) && ($signed(o_out_z) >= -ONE),
        "normalised component exceeds one")

endmodule

`default_nettype wire

// ===== src/qn_front.sv =====
// ----------------------------------------------------------------------------
// Quaternion NLERP front end
// Dot product, shortest-path flip, blend, rounding and sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module qn_front import qn_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [3:0][W_IN-1:0]       i_a,
    input  logic [3:0][W_IN-1:0]       i_b,
    input  logic [W_BLEND-1:0]         i_blend,
    output t_front                     o_front
);

    logic [4:0]               r_vld;
    logic [W_BLEND-1:0]       f_sat;
    logic [W_BLEND-1:0]       g;
    logic signed [31:0]       n1_ab [4];
    logic signed [31:0]       n1_ga [4];
    logic signed [31:0]       n1_fb [4];
    logic signed [31:0]       r1_ab [4];
    logic signed [31:0]       r1_ga [4];
    logic signed [31:0]       r1_fb [4];
    logic signed [33:0]       n2_dot;
    logic                     r2_flip;
    logic signed [31:0]       r2_ga [4];
    logic signed [31:0]       r2_fb [4];
    logic signed [32:0]       n3_c [4];
    logic signed [32:0]       r3_c [4];
    logic [32:0]              n4_abs [4];
    logic [32:0]              n4_rnd [4];
    logic [3:0]               r4_neg;
    logic [3:0][W_MAG-1:0]    r4_mag;
    logic [3:0][31:0]         n5_sq;
    logic [3:0][31:0]         r5_sq;
    logic [3:0]               r5_neg;
    logic [3:0][W_MAG-1:0]    r5_mag;
    t_front                   n_front;
    t_front                   r_front;

    always_comb begin
        f_sat = (i_blend > W_BLEND'(ONE)) ? W_BLEND'(ONE) : i_blend;
        g     = W_BLEND'(ONE) - f_sat;
        for (int i = 0; i < 4; i++) begin
            n1_ab[i] = $signed(i_a[i]) * $signed(i_b[i]);
            n1_ga[i] = $signed({1'b0, g}) * $signed(i_a[i]);
            n1_fb[i] = $signed({1'b0, f_sat}) * $signed(i_b[i]);
        end
    end

    assign n2_dot = 34'(r1_ab[0]) + 34'(r1_ab[1]) + 34'(r1_ab[2]) + 34'(r1_ab[3]);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            // Negating b scales to negating its blended product.
            n3_c[i] = r2_flip ? 33'(r2_ga[i]) - 33'(r2_fb[i])
                              : 33'(r2_ga[i]) + 33'(r2_fb[i]);
            n4_abs[i] = r3_c[i][32] ? 33'(-r3_c[i]) : 33'(r3_c[i]);
            n4_rnd[i] = (n4_abs[i] + 33'(ONE / 2)) >> FRAC_BITS;
            n5_sq[i]  = 32'(r4_mag[i]) * 32'(r4_mag[i]);
        end
    end

    always_comb begin
        n_front.vld = r_vld[4];
        n_front.neg = r5_neg;
        n_front.mag = r5_mag;
        n_front.sum = W_SUM'(r5_sq[0]) + W_SUM'(r5_sq[1])
                    + W_SUM'(r5_sq[2]) + W_SUM'(r5_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_front.vld <= 1'b0;
        end else if (i_en) begin
            r_vld   <= {r_vld[3:0], i_vld};
            r_front <= n_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_flip <= n2_dot[33];
            for (int i = 0; i < 4; i++) begin
                r1_ab[i]  <= n1_ab[i];
                r1_ga[i]  <= n1_ga[i];
                r1_fb[i]  <= n1_fb[i];
                r2_ga[i]  <= r1_ga[i];
                r2_fb[i]  <= r1_fb[i];
                r3_c[i]   <= n3_c[i];
                r4_neg[i] <= r3_c[i][32];
                r4_mag[i] <= n4_rnd[i][W_MAG-1:0];
            end
            r5_sq  <= n5_sq;
            r5_neg <= r4_neg;
            r5_mag <= r4_mag;
        end
    end

    assign o_front = r_front;

endmodule

`default_nettype wire

// ===== src/qn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Quaternion NLERP square root cell
// One restoring square root digit: settles one bit of the root per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module qn_sqrt_cell import qn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_sq    i_sq,
    output t_sq    o_sq
);

    logic [W_REM+1:0] cur;
    logic [W_REM+1:0] trial;
    t_sq              n_sq;
    t_sq              r_sq;

    always_comb begin
        cur      = {i_sq.rem, i_sq.rad[W_RAD-1 -: 2]};
        trial    = {1'b0, i_sq.root, 2'b01};
        n_sq     = i_sq;
        n_sq.rad = {i_sq.rad[W_RAD-3:0], 2'b00};
        if (cur >= trial) begin
            n_sq.rem  = W_REM'(cur - trial);
            n_sq.root = {i_sq.root[W_ROOT-2:0], 1'b1};
        end else begin
            n_sq.rem  = cur[W_REM-1:0];
            n_sq.root = {i_sq.root[W_ROOT-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.vld <= 1'b0;
        end else if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

// ===== src/qn_div_cell.sv =====
// ----------------------------------------------------------------------------
// Quaternion NLERP divider cell
// One restoring division step on all four components against the length.
// ----------------------------------------------------------------------------
`default_nettype none

module qn_div_cell import qn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_div   i_dv,
    output t_div   o_dv
);

    t_div n_dv;
    t_div r_dv;

    always_comb begin
        n_dv      = i_dv;
        n_dv.dsor = i_dv.dsor >> 1;
        for (int i = 0; i < 4; i++) begin
            if (i_dv.part[i] >= i_dv.dsor) begin
                n_dv.part[i] = i_dv.part[i] - i_dv.dsor;
                n_dv.quo[i]  = {i_dv.quo[i][W_QUO-2:0], 1'b1};
            end else begin
                n_dv.quo[i]  = {i_dv.quo[i][W_QUO-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv.vld <= 1'b0;
        end else if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_dv = r_dv;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Quaternion NLERP testbench
// Drives random and corner-case quaternion pairs through the blend pipeline
// and checks every result against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import qn_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1630;

    typedef struct packed {
        logic signed [W_IN-1:0] a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
        logic [W_BLEND-1:0]     blend;
    } t_request;

    typedef struct packed {
        logic signed [W_IN-1:0] w, x, y, z;
        logic                   degen;
    } t_blended;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_degenerate;
    logic signed [W_IN-1:0] i_a_w = '0, i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [W_IN-1:0] i_b_w = '0, i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic [W_BLEND-1:0] i_blend = '0;
    logic signed [W_IN-1:0] o_out_w, o_out_x, o_out_y, o_out_z;

    t_request pending_requests[$];
    t_blended expected_blends[$];
    int  mismatch_count = 0;
    int  result_count = 0;
    int  degen_count = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_phase = 0;
    bit  stimulus_done = 1'b0;

    quaternion_nlerp u_top (.*);

    always #4 i_clk = ~i_clk;

    // Saturating 16-bit signed result from sign and magnitude.
    function automatic logic signed [W_IN-1:0] clamp16(bit neg, longint unsigned mag);
        if (neg) begin
            return (mag > 32768) ? -16'sd32768 : W_IN'(-longint'(mag));
        end
        return (mag > 32767) ? 16'sd32767 : W_IN'(mag);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_blended predict_blend(t_request q);
        longint a[4], b[4], r[4];
        longint dot = 0, f, g, c, m;
        longint unsigned s = 0, len, num, mag;
        logic signed [W_IN-1:0] o[4];
        t_blended e;
        a = '{q.a_w, q.a_x, q.a_y, q.a_z};
        b = '{q.b_w, q.b_x, q.b_y, q.b_z};
        for (int i = 0; i < 4; i++) dot += a[i] * b[i];
        f = q.blend;
        if (f > ONE) f = ONE;
        g = ONE - f;
        for (int i = 0; i < 4; i++) begin
            c = g * a[i] + f * ((dot < 0) ? -b[i] : b[i]);
            m = ((c < 0 ? -c : c) + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
            r[i] = (c < 0) ? -m : m;
            s += r[i] * r[i];
        end
        if (s == 0) begin
            e.w = clamp16(1'b0, ONE);
            e.x = '0; e.y = '0; e.z = '0;
            e.degen = 1'b1;
            return e;
        end
        len = int_sqrt(s << 20);
        for (int i = 0; i < 4; i++) begin
            mag = (r[i] < 0) ? -r[i] : r[i];
            num = (mag * ONE) << 10;
            o[i] = clamp16(r[i] < 0, (num + (len >> 1)) / len);
        end
        e.w = o[0]; e.x = o[1]; e.y = o[2]; e.z = o[3];
        e.degen = 1'b0;
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", result_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic signed [W_IN-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return W_IN'($urandom);
            1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            2: return W_IN'($urandom_range(0, 4)) - 16'sd2;
            default: return W_IN'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_request rand_request();
        t_request q;
        q.a_w = rand_comp(); q.a_x = rand_comp(); q.a_y = rand_comp(); q.a_z = rand_comp();
        case ($urandom_range(0, 7))
            // Opposite or equal pairs: the shortest-path flip makes both blend back to a.
            0: begin
                q.b_w = -q.a_w; q.b_x = -q.a_x; q.b_y = -q.a_y; q.b_z = -q.a_z;
            end
            1: begin
                q.b_w = q.a_w; q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z;
            end
            default: begin
                q.b_w = rand_comp(); q.b_x = rand_comp();
                q.b_y = rand_comp(); q.b_z = rand_comp();
            end
        endcase
        case ($urandom_range(0, 5))
            0: q.blend = W_BLEND'($urandom);
            1: q.blend = $urandom_range(0, 1) ? W_BLEND'(ONE) : '0;
            default: q.blend = W_BLEND'($urandom_range(0, ONE));
        endcase
        return q;
    endfunction

    function automatic t_request make_request(int aw, int ax, int ay, int az,
                                              int bw, int bx, int by, int bz, int f);
        t_request q;
        q.a_w = W_IN'(aw); q.a_x = W_IN'(ax); q.a_y = W_IN'(ay); q.a_z = W_IN'(az);
        q.b_w = W_IN'(bw); q.b_x = W_IN'(bx); q.b_y = W_IN'(by); q.b_z = W_IN'(bz);
        q.blend = W_BLEND'(f);
        return q;
    endfunction

    initial begin
        // Directed: extremes, shortest-path flip, zero-length blends, blend saturation.
        pending_requests.push_back(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 8192));
        pending_requests.push_back(make_request(16384, 0, 0, 0, -16384, 0, 0, 0, 8192));
        pending_requests.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 32767));
        pending_requests.push_back(make_request(16384, 0, 0, 0, 0, 16384, 0, 0, 16385));
        pending_requests.push_back(make_request(0, 16384, 0, 0, 0, 0, 16384, 0, 0));
        pending_requests.push_back(make_request(-32768, -32768, -32768, -32768,
                                                32767, 32767, 32767, 32767, 8192));
        pending_requests.push_back(make_request(32767, 32767, 32767, 32767,
                                                32767, 32767, 32767, 32767, 16384));
        pending_requests.push_back(make_request(-32768, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(1, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(0, 0, 0, 1, 0, 0, 0, -1, 8192));
        pending_requests.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 1, 1));
        pending_requests.push_back(make_request(11585, 11585, 0, 0, -11585, 11585, 0, 0, 16384));
        pending_requests.push_back(make_request(8192, -8192, 8192, -8192,
                                                -8192, 8192, -8192, 8192, 4096));
        pending_requests.push_back(make_request(-1, -1, -1, -1, -1, -1, -1, -1, 21845));
        for (int i = 0; i < N_RANDOM; i++) pending_requests.push_back(rand_request());
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            automatic bit taken = i_valid && o_ready;
            if (taken) expected_blends.push_back(predict_blend({i_a_w, i_a_x, i_a_y, i_a_z,
                i_b_w, i_b_x, i_b_y, i_b_z, i_blend}));
            if (!i_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    i_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end else begin
                    automatic t_request q = pending_requests.pop_front();
                    i_valid <= 1'b1;
                    {i_a_w, i_a_x, i_a_y, i_a_z, i_b_w, i_b_x, i_b_y, i_b_z, i_blend} <= q;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Receiver: stall pattern alternates between free-running and choppy phases.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_phase <= (stall_phase + 1) % 600;
            if (stall_phase < 200) i_ready <= 1'b1;
            else if (stall_phase < 400) i_ready <= ($urandom_range(0, 3) != 0);
            else i_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            automatic t_blended e;
            result_count++;
            if (expected_blends.size() == 0) begin
                $display("MISMATCH result %0d arrived with nothing outstanding", result_count);
                mismatch_count++;
            end else begin
                e = expected_blends.pop_front();
                if (o_out_w !== e.w) report_mismatch("w", o_out_w, e.w);
                if (o_out_x !== e.x) report_mismatch("x", o_out_x, e.x);
                if (o_out_y !== e.y) report_mismatch("y", o_out_y, e.y);
                if (o_out_z !== e.z) report_mismatch("z", o_out_z, e.z);
                if (o_degenerate !== e.degen) report_mismatch("degenerate", o_degenerate, e.degen);
                if (e.degen) degen_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", expected_blends.size());
            $display("quaternion_nlerp verification failed");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done && !i_valid);
        wait (expected_blends.size() == 0);
        repeat (120) @(posedge i_clk);
        $display("Checked %0d blended quaternions, %0d of them zero-length.",
                 result_count, degen_count);
        if (mismatch_count == 0 && expected_blends.size() == 0) begin
            $display("quaternion_nlerp verification clean");
        end else begin
            $display("quaternion_nlerp verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== quaternion_nlerp.f =====
+incdir+src
src/qn_pkg.sv
src/qn_front.sv
src/qn_sqrt_cell.sv
src/qn_div_cell.sv
src/quaternion_nlerp.sv
test/tb_top.sv
